FILE: rtl/fqks_pkg.sv
`timescale 1ns / 1ps
// Shared constants, operation codes and result word type for the key-search FIFO.
// No dependencies.
package fqks_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int KEY_WIDTH   = 32;
   localparam int PTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);
   localparam int OP_WIDTH    = 2;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_SEARCH  = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef struct packed {
      logic                        success;
      logic signed [KEY_WIDTH-1:0] key_out;
      logic [PTR_WIDTH-1:0]        match_position;
      logic                        full_drop;
      logic [CNT_WIDTH-1:0]        entry_count;
      logic                        is_empty;
      logic signed [KEY_WIDTH-1:0] head_key;
      logic signed [KEY_WIDTH-1:0] tail_key;
   } result_type;

   function automatic logic [PTR_WIDTH-1:0] next_slot(input logic [PTR_WIDTH-1:0] slot);
      if (slot == PTR_WIDTH'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return slot + PTR_WIDTH'(1);
   endfunction

endpackage

FILE: rtl/fqks_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module fqks_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/fqks_seq.sv
`timescale 1ns / 1ps
// Operation sequencer: queue pointers, occupancy, head/tail key tracking and the search scan.
// Depends on fqks_pkg and fqks_ram.
module fqks_seq (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [fqks_pkg::OP_WIDTH-1:0]        req_operation,
   input  logic signed [fqks_pkg::KEY_WIDTH-1:0] req_key_in,
   output logic                                 done,
   output fqks_pkg::result_type                 result
);
   import fqks_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DEQ_RD,
      S_DEQ_HD,
      S_SEARCH,
      S_DONE
   } state_type;

   state_type                  state_ff, state_in;
   logic [KEY_WIDTH-1:0]       key_ff, key_in;
   logic [PTR_WIDTH-1:0]       head_ff, head_in;
   logic [PTR_WIDTH-1:0]       tail_ff, tail_in;
   logic [CNT_WIDTH-1:0]       count_ff, count_in;
   logic [PTR_WIDTH-1:0]       scan_slot_ff, scan_slot_in;
   logic [PTR_WIDTH-1:0]       scan_idx_ff, scan_idx_in;
   logic                       success_ff, success_in;
   logic [KEY_WIDTH-1:0]       key_out_ff, key_out_in;
   logic [PTR_WIDTH-1:0]       pos_ff, pos_in;
   logic                       drop_ff, drop_in;
   logic [KEY_WIDTH-1:0]       head_key_ff, head_key_in;
   logic [KEY_WIDTH-1:0]       tail_key_ff, tail_key_in;

   logic                       wr_en;
   logic [PTR_WIDTH-1:0]       rd_addr;
   logic [KEY_WIDTH-1:0]       rd_data;

   fqks_ram #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (KEY_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (req_key_in),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      scan_slot_in = scan_slot_ff;
      scan_idx_in  = scan_idx_ff;
      success_in   = success_ff;
      key_out_in   = key_out_ff;
      pos_in       = pos_ff;
      drop_in      = drop_ff;
      head_key_in  = head_key_ff;
      tail_key_in  = tail_key_ff;
      wr_en        = 1'b0;
      rd_addr      = head_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               key_in     = req_key_in;
               success_in = 1'b0;
               key_out_in = '0;
               pos_in     = '0;
               drop_in    = 1'b0;
               state_in   = S_DONE;
               case (op_type'(req_operation))
                  OP_ENQUEUE: begin
                     if (count_ff == CNT_WIDTH'(QUEUE_DEPTH)) begin
                        drop_in = 1'b1;
                     end else begin
                        wr_en       = 1'b1;
                        tail_in     = next_slot(tail_ff);
                        count_in    = count_ff + CNT_WIDTH'(1);
                        tail_key_in = req_key_in;
                        success_in  = 1'b1;
                        if (count_ff == '0) begin
                           head_key_in = req_key_in;
                        end
                     end
                  end
                  OP_DEQUEUE: begin
                     if (count_ff != '0) begin
                        state_in = S_DEQ_RD;
                     end
                  end
                  OP_SEARCH: begin
                     if (count_ff != '0) begin
                        scan_slot_in = head_ff;
                        scan_idx_in  = '0;
                        state_in     = S_SEARCH;
                     end
                  end
                  default: begin
                     head_in    = '0;
                     tail_in    = '0;
                     count_in   = '0;
                     success_in = 1'b1;
                  end
               endcase
            end
         end
         S_DEQ_RD: begin
            key_out_in = rd_data;
            success_in = 1'b1;
            head_in    = next_slot(head_ff);
            count_in   = count_ff - CNT_WIDTH'(1);
            rd_addr    = next_slot(head_ff);
            state_in   = (count_ff == CNT_WIDTH'(1)) ? S_DONE : S_DEQ_HD;
         end
         S_DEQ_HD: begin
            head_key_in = rd_data;
            state_in    = S_DONE;
         end
         S_SEARCH: begin
            rd_addr = next_slot(scan_slot_ff);
            if (rd_data == key_ff) begin
               success_in = 1'b1;
               pos_in     = scan_idx_ff;
               state_in   = S_DONE;
            end else if (CNT_WIDTH'(scan_idx_ff) + CNT_WIDTH'(1) == count_ff) begin
               state_in = S_DONE;
            end else begin
               scan_idx_in  = scan_idx_ff + PTR_WIDTH'(1);
               scan_slot_in = next_slot(scan_slot_ff);
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      key_ff       <= key_in;
      scan_slot_ff <= scan_slot_in;
      scan_idx_ff  <= scan_idx_in;
      success_ff   <= success_in;
      key_out_ff   <= key_out_in;
      pos_ff       <= pos_in;
      drop_ff      <= drop_in;
      head_key_ff  <= head_key_in;
      tail_key_ff  <= tail_key_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign done = (state_ff == S_DONE);

   always_comb begin
      result.success        = success_ff;
      result.key_out        = key_out_ff;
      result.match_position = pos_ff;
      result.full_drop      = drop_ff;
      result.entry_count    = count_ff;
      result.is_empty       = (count_ff == '0);
      result.head_key       = (count_ff == '0) ? '0 : head_key_ff;
      result.tail_key       = (count_ff == '0) ? '0 : tail_key_ff;
   end

endmodule

FILE: rtl/fifo_queue_with_key_search_core.sv
`timescale 1ns / 1ps
// Top level of the key-search FIFO: sequencer plus the registered result word.
// Depends on fqks_pkg and fqks_seq.
//
//   Channel    Handshake            Fields
//   request    start / busy         req_operation, req_key_in
//   response   rsp_strobe (1 cycle) rsp_success .. rsp_tail_key
//
// Enqueue, clear, and dequeue or search on an empty queue: straight from idle to done; word registered from done.
// Dequeue: key read, then new head read from the RAM (skipped when the last entry leaves), then done.
// Search: scans entries from the head up to the first match (max 16), one RAM read per
// cycle. Synchronous reset empties the queue; RAM contents kept.
// The receiver cannot stall; each response word is shown for one cycle.
module fifo_queue_with_key_search_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [fqks_pkg::OP_WIDTH-1:0]         req_operation,
   input  logic signed [fqks_pkg::KEY_WIDTH-1:0] req_key_in,
   output logic                                  rsp_strobe,
   output logic                                  rsp_success,
   output logic signed [fqks_pkg::KEY_WIDTH-1:0] rsp_key_out,
   output logic [fqks_pkg::PTR_WIDTH-1:0]        rsp_match_position,
   output logic                                  rsp_full_drop,
   output logic [fqks_pkg::CNT_WIDTH-1:0]        rsp_entry_count,
   output logic                                  rsp_is_empty,
   output logic signed [fqks_pkg::KEY_WIDTH-1:0] rsp_head_key,
   output logic signed [fqks_pkg::KEY_WIDTH-1:0] rsp_tail_key
);
   import fqks_pkg::*;

   logic       done;
   result_type result;
   logic       strobe_ff;
   result_type word_ff;

   fqks_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_key_in    (req_key_in),
      .done          (done),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= done;
      end
      if (done) begin
         word_ff <= result;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_success        = word_ff.success;
   assign rsp_key_out        = word_ff.key_out;
   assign rsp_match_position = word_ff.match_position;
   assign rsp_full_drop      = word_ff.full_drop;
   assign rsp_entry_count    = word_ff.entry_count;
   assign rsp_is_empty       = word_ff.is_empty;
   assign rsp_head_key       = word_ff.head_key;
   assign rsp_tail_key       = word_ff.tail_key;

endmodule

FILE: rtl/fqks_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the key-search FIFO, bound to the top level.
// Depends on fqks_pkg.
module fqks_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic                                  rsp_strobe,
   input logic                                  rsp_success,
   input logic signed [fqks_pkg::KEY_WIDTH-1:0] rsp_key_out,
   input logic                                  rsp_full_drop,
   input logic [fqks_pkg::CNT_WIDTH-1:0]        rsp_entry_count,
   input logic                                  rsp_is_empty
);
   import fqks_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response word without preceding busy");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_is_empty == (rsp_entry_count == '0)))
      else $error("empty flag disagrees with entry count");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_full_drop |->
         !rsp_success && rsp_entry_count == CNT_WIDTH'(QUEUE_DEPTH))
      else $error("drop reported while queue not full");

   a_keyout_success: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_key_out != '0 |-> rsp_success)
      else $error("dequeued key on a failed operation");

endmodule

bind fifo_queue_with_key_search_core fqks_checker u_fqks_checker (.*);

FILE: tb/tb_fifo_queue_with_key_search_core.sv
`timescale 1ns / 1ps
// Self-checking bench for the key-search FIFO: queue-fed command driver, shadow queue
// predictor and response checker. Depends on fqks_pkg and fifo_queue_with_key_search_core.
module tb_fifo_queue_with_key_search_core;
   import fqks_pkg::*;

   localparam int CLK_PERIOD     = 4;
   localparam int RANDOM_ITEMS   = 1700;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int POOL_SIZE      = 6;

   typedef struct {
      op_type                      op;
      logic signed [KEY_WIDTH-1:0] key;
      bit                          drain_first;
   } cmd_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [OP_WIDTH-1:0]           req_operation = '0;
   logic signed [KEY_WIDTH-1:0]   req_key_in = '0;
   logic                          rsp_strobe;
   logic                          rsp_success;
   logic signed [KEY_WIDTH-1:0]   rsp_key_out;
   logic [PTR_WIDTH-1:0]          rsp_match_position;
   logic                          rsp_full_drop;
   logic [CNT_WIDTH-1:0]          rsp_entry_count;
   logic                          rsp_is_empty;
   logic signed [KEY_WIDTH-1:0]   rsp_head_key;
   logic signed [KEY_WIDTH-1:0]   rsp_tail_key;

   cmd_type                       cmd_queue[$];
   result_type                    predicted_words[$];
   logic                          cmd_taken = 1'b0;
   int                            fail_count = 0;
   int                            idle_cycles = 0;
   int                            gap_left = 0;
   int                            burst_left = 0;

   logic signed [KEY_WIDTH-1:0]   shadow_keys[QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]          shadow_head = '0;
   logic [PTR_WIDTH-1:0]          shadow_tail = '0;
   logic [CNT_WIDTH-1:0]          shadow_count = '0;

   fifo_queue_with_key_search_core dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_key_in         (req_key_in),
      .rsp_strobe         (rsp_strobe),
      .rsp_success        (rsp_success),
      .rsp_key_out        (rsp_key_out),
      .rsp_match_position (rsp_match_position),
      .rsp_full_drop      (rsp_full_drop),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_is_empty       (rsp_is_empty),
      .rsp_head_key       (rsp_head_key),
      .rsp_tail_key       (rsp_tail_key)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic logic [PTR_WIDTH-1:0] wrap_inc(input logic [PTR_WIDTH-1:0] idx);
      return (idx == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   // Applies one command to the shadow queue and returns the word it should produce.
   function automatic result_type apply_queue_op(input op_type op,
                                                 input logic signed [KEY_WIDTH-1:0] key);
      result_type           word;
      logic [PTR_WIDTH-1:0] slot;
      logic [PTR_WIDTH-1:0] last;
      bit                   found;
      word  = '0;
      found = 1'b0;
      case (op)
         OP_ENQUEUE: begin
            if (shadow_count == CNT_WIDTH'(QUEUE_DEPTH)) begin
               word.full_drop = 1'b1;
            end else begin
               shadow_keys[shadow_tail] = key;
               shadow_tail  = wrap_inc(shadow_tail);
               shadow_count = shadow_count + 1'b1;
               word.success = 1'b1;
            end
         end
         OP_DEQUEUE: begin
            if (shadow_count != 0) begin
               word.key_out = shadow_keys[shadow_head];
               shadow_head  = wrap_inc(shadow_head);
               shadow_count = shadow_count - 1'b1;
               word.success = 1'b1;
            end
         end
         OP_SEARCH: begin
            slot = shadow_head;
            for (int i = 0; i < shadow_count && !found; i++) begin
               if (shadow_keys[slot] == key) begin
                  found               = 1'b1;
                  word.success        = 1'b1;
                  word.match_position = PTR_WIDTH'(i);
               end
               slot = wrap_inc(slot);
            end
         end
         default: begin
            shadow_head  = '0;
            shadow_tail  = '0;
            shadow_count = '0;
            word.success = 1'b1;
         end
      endcase
      word.entry_count = shadow_count;
      word.is_empty    = (shadow_count == 0);
      if (shadow_count != 0) begin
         last          = (shadow_tail == 0) ? PTR_WIDTH'(QUEUE_DEPTH - 1) : shadow_tail - 1'b1;
         word.head_key = shadow_keys[shadow_head];
         word.tail_key = shadow_keys[last];
      end
      return word;
   endfunction

   task automatic report_error(input string what);
      $display("ERROR at %0t ns: %s", $time, what);
      fail_count++;
   endtask

   task automatic add_cmd(input op_type op, input logic signed [KEY_WIDTH-1:0] key,
                          input bit drain_first);
      cmd_type c;
      c.op          = op;
      c.key         = key;
      c.drain_first = drain_first;
      cmd_queue.push_back(c);
   endtask

   // driver: bursts with random gaps, optional hold-off until the queue of words drains
   always @(negedge clock) begin : drive_req
      cmd_type  c;
      bit       launch;
      launch = 1'b0;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || cmd_taken) begin
         if (gap_left != 0) begin
            gap_left--;
         end else if (cmd_queue.size() != 0) begin
            launch = !(cmd_queue[0].drain_first && predicted_words.size() != 0);
         end
         if (launch) begin
            c = cmd_queue.pop_front();
            start         <= 1'b1;
            req_operation <= c.op;
            req_key_in    <= c.key;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end else begin
            start         <= 1'b0;
            req_operation <= OP_WIDTH'($urandom());
            req_key_in    <= $urandom();
         end
      end
   end

   // monitor: check response words, predict accepted commands, watchdog
   always @(posedge clock) begin : check_rsp
      result_type want;
      bit         taken;
      taken = !reset && start && !busy;
      if (!reset) begin
         if (rsp_strobe) begin
            if (predicted_words.size() == 0) begin
               report_error("response word with nothing predicted");
            end else begin
               want = predicted_words.pop_front();
               if (rsp_success !== want.success)
                  report_error($sformatf("success %0b, want %0b", rsp_success, want.success));
               if (rsp_key_out !== want.key_out)
                  report_error($sformatf("key_out %0d, want %0d", rsp_key_out, want.key_out));
               if (rsp_match_position !== want.match_position)
                  report_error($sformatf("match_position %0d, want %0d",
                                         rsp_match_position, want.match_position));
               if (rsp_full_drop !== want.full_drop)
                  report_error($sformatf("full_drop %0b, want %0b",
                                         rsp_full_drop, want.full_drop));
               if (rsp_entry_count !== want.entry_count)
                  report_error($sformatf("entry_count %0d, want %0d",
                                         rsp_entry_count, want.entry_count));
               if (rsp_is_empty !== want.is_empty)
                  report_error($sformatf("is_empty %0b, want %0b", rsp_is_empty, want.is_empty));
               if (rsp_head_key !== want.head_key)
                  report_error($sformatf("head_key %0d, want %0d", rsp_head_key, want.head_key));
               if (rsp_tail_key !== want.tail_key)
                  report_error($sformatf("tail_key %0d, want %0d", rsp_tail_key, want.tail_key));
            end
         end
         if (taken) begin
            predicted_words.push_back(apply_queue_op(op_type'(req_operation), req_key_in));
         end
         if (taken || rsp_strobe) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
      cmd_taken <= taken;
   end

   initial begin : stimulus
      logic signed [KEY_WIDTH-1:0] fill_keys[QUEUE_DEPTH];
      logic signed [KEY_WIDTH-1:0] key_pool[POOL_SIZE];
      logic signed [KEY_WIDTH-1:0] key;
      op_type                      op;
      int                          issued;
      int                          phase_len;
      int                          enq_pct;
      int                          deq_pct;
      int                          roll;

      fill_keys = '{32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1, 32'sd0, 32'sh5555_5555,
                    32'shAAAA_AAAA, 32'sd1, 32'sd2, 32'sh5555_5555, 32'sh1234_5678,
                    32'sh0F0F_0F0F, 32'shF0F0_F0F0, 32'sh7FFF_FFFE, 32'sh8000_0001,
                    32'sd3, 32'sh0001_0000};

      // directed: empty cases, fill to full, drop, searches, dequeue, clear
      add_cmd(OP_DEQUEUE, 32'sd9, 1'b0);
      add_cmd(OP_SEARCH, 32'sd0, 1'b0);
      foreach (fill_keys[i]) add_cmd(OP_ENQUEUE, fill_keys[i], 1'b0);
      add_cmd(OP_ENQUEUE, 32'sh77, 1'b0);
      add_cmd(OP_SEARCH, 32'sh0001_0000, 1'b0);
      add_cmd(OP_SEARCH, 32'sh5555_5555, 1'b0);
      add_cmd(OP_SEARCH, 32'sd42, 1'b0);
      add_cmd(OP_DEQUEUE, 32'sd0, 1'b0);
      add_cmd(OP_CLEAR, 32'sd0, 1'b0);
      add_cmd(OP_DEQUEUE, -32'sd1, 1'b0);

      // random phases: filling, draining or balanced, keys mostly from a small pool
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         phase_len = $urandom_range(40, 120);
         case ($urandom_range(0, 2))
            0:       begin enq_pct = 65; deq_pct = 12; end
            1:       begin enq_pct = 15; deq_pct = 60; end
            default: begin enq_pct = 35; deq_pct = 35; end
         endcase
         foreach (key_pool[k]) begin
            case ($urandom_range(0, 7))
               0:       key_pool[k] = 32'sh8000_0000;
               1:       key_pool[k] = 32'sh7FFF_FFFF;
               2:       key_pool[k] = -32'sd1;
               3:       key_pool[k] = 32'sd0;
               default: key_pool[k] = $urandom();
            endcase
         end
         for (int j = 0; j < phase_len; j++) begin
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
               op = OP_CLEAR;
            end else if (roll < 2 + enq_pct) begin
               op = OP_ENQUEUE;
            end else if (roll < 2 + enq_pct + deq_pct) begin
               op = OP_DEQUEUE;
            end else begin
               op = OP_SEARCH;
            end
            if ((op == OP_ENQUEUE || op == OP_SEARCH) && $urandom_range(0, 3) != 0) begin
               key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else begin
               key = $urandom();
            end
            add_cmd(op, key, j == 0);
         end
         issued += phase_len;
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (cmd_queue.size() != 0 || start || predicted_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/fqks_pkg.sv
rtl/fqks_ram.sv
rtl/fqks_seq.sv
rtl/fifo_queue_with_key_search_core.sv
rtl/fqks_checker.sv
tb/tb_fifo_queue_with_key_search_core.sv
